// File: design/hfd_pkg.sv
// hfd_pkg: shared constants for the hdlc frame deframer
// holds function codes, frame byte constants and field widths
// no dependencies
package hfd_pkg;

    localparam int BUF_SIZE_DEF = 512;

    localparam int DATA_W  = 8;
    localparam int INDEX_W = 9;
    localparam int LEN_W   = 10;
    localparam int EXP_W   = 12;
    localparam int HDR_N   = 3;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic KIND_TRASH    = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    localparam logic [DATA_W-1:0] FLAG_BYTE   = 8'h7E;
    localparam logic [DATA_W-1:0] FMT_MASK    = 8'hF0;
    localparam logic [DATA_W-1:0] FMT_TYPE    = 8'hA0;
    localparam logic [DATA_W-1:0] LEN_HI_MASK = 8'h0F;

endpackage

// File: design/hdlc_frame_deframer_core.sv
// hdlc_frame_deframer_core: byte-serial frame deframer with a frame buffer memory
// depends on hfd_pkg
//
// channel   direction   handshake                fields
// in        sink        i_in_valid / o_in_stall  i_func, i_data_byte, i_read_index
// out       source      o_out_valid / i_out_stall o_frame_ready, o_frame_kind,
//                                                 o_frame_length, o_read_data
//
// one transaction accepted per cycle while the input is not stalled, its result valid on the next cycle
// the buffer memory takes at most one write or one read per transaction, read data registered
// the first three buffer bytes live in flops so the whole header moves together
// synchronous active-low reset clears control state only, no clearing pass
// input stalls only while a result is held by a stalled output
module hdlc_frame_deframer_core #(
    parameter int BUF_SIZE = hfd_pkg::BUF_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_func,
    input  logic [hfd_pkg::DATA_W-1:0]   i_data_byte,
    input  logic [hfd_pkg::INDEX_W-1:0]  i_read_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_frame_ready,
    output logic                         o_frame_kind,
    output logic [hfd_pkg::LEN_W-1:0]    o_frame_length,
    output logic [hfd_pkg::DATA_W-1:0]   o_read_data
);

    localparam int AW   = $clog2(BUF_SIZE);
    localparam int WP_W = $clog2(BUF_SIZE + 1);
    localparam int CW   = (WP_W > hfd_pkg::EXP_W + 1) ? WP_W : hfd_pkg::EXP_W + 1;
    localparam logic [CW-1:0] BUF_CW = CW'(BUF_SIZE);

    typedef enum logic [1:0] {PH_FLAG, PH_FMT, PH_LEN, PH_BODY} t_phase;

    t_phase                        r_phase, n_phase;
    logic [WP_W-1:0]               r_wp, n_wp;
    logic [hfd_pkg::EXP_W-1:0]     r_exp, n_exp;
    logic                          r_kind, n_kind;
    logic [hfd_pkg::LEN_W-1:0]     r_len, n_len;
    logic                          r_ready, n_ready;
    logic                          r_out_valid;
    logic                          r_rd_sel_mem;
    logic [hfd_pkg::DATA_W-1:0]    r_rd_byte;
    logic [hfd_pkg::DATA_W-1:0]    r_mem_q;
    logic [hfd_pkg::DATA_W-1:0]    r_fmt;
    logic [hfd_pkg::DATA_W-1:0]    r_hdr [hfd_pkg::HDR_N];
    logic [hfd_pkg::DATA_W-1:0]    mem [BUF_SIZE];

    logic                          accept;
    logic                          push;
    logic                          rd;
    logic [WP_W-1:0]               wp_inc;
    logic [CW-1:0]                 wp_cw;
    logic [CW-1:0]                 wp_inc_cw;
    logic [CW-1:0]                 end_pos;
    logic [CW-1:0]                 idx_cw;
    logic                          idx_in_buf;
    logic                          idx_in_hdr;
    logic                          wr_en;
    logic                          wr_hdr;
    logic                          wr_mem;
    logic                          hdr_move;
    logic                          rd_mem_en;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = accept && (i_func == hfd_pkg::FUNC_PUSH);
    assign rd         = accept && (i_func == hfd_pkg::FUNC_READ);

    assign wp_inc    = r_wp + WP_W'(1);
    assign wp_cw     = CW'(r_wp);
    assign wp_inc_cw = CW'(wp_inc);
    assign end_pos   = CW'(r_exp) + CW'(2);

    assign idx_cw     = CW'(i_read_index);
    assign idx_in_buf = idx_cw < BUF_CW;
    assign idx_in_hdr = idx_cw < CW'(hfd_pkg::HDR_N);
    assign rd_mem_en  = rd && idx_in_buf && !idx_in_hdr;

    assign wr_hdr = wr_en && (wp_cw < CW'(hfd_pkg::HDR_N));
    assign wr_mem = wr_en && !(wp_cw < CW'(hfd_pkg::HDR_N));

    always_comb begin
        n_phase  = r_phase;
        n_wp     = r_wp;
        n_exp    = r_exp;
        n_kind   = r_kind;
        n_len    = r_len;
        n_ready  = 1'b0;
        wr_en    = 1'b0;
        hdr_move = 1'b0;
        if (push) begin
            if (wp_cw >= BUF_CW) begin
                // buffer full: drop the byte and report it all as trash
                n_wp    = '0;
                n_phase = PH_FLAG;
                n_exp   = '0;
                n_ready = 1'b1;
                n_kind  = hfd_pkg::KIND_TRASH;
                n_len   = BUF_CW[hfd_pkg::LEN_W-1:0];
            end else begin
                unique case (r_phase)
                    PH_FLAG: begin
                        wr_en = 1'b1;
                        n_wp  = wp_inc;
                        if (i_data_byte == hfd_pkg::FLAG_BYTE) begin
                            n_phase = PH_FMT;
                        end
                    end
                    PH_FMT: begin
                        wr_en = 1'b1;
                        n_wp  = wp_inc;
                        if ((i_data_byte & hfd_pkg::FMT_MASK) == hfd_pkg::FMT_TYPE) begin
                            n_phase = PH_LEN;
                            if (wp_cw > CW'(1)) begin
                                n_ready = 1'b1;
                                n_kind  = hfd_pkg::KIND_TRASH;
                                n_len   = wp_cw[hfd_pkg::LEN_W-1:0] - hfd_pkg::LEN_W'(1);
                            end
                        end else if (i_data_byte == hfd_pkg::FLAG_BYTE) begin
                            n_ready = 1'b1;
                            n_kind  = hfd_pkg::KIND_TRASH;
                            n_len   = wp_cw[hfd_pkg::LEN_W-1:0];
                        end else begin
                            n_phase = PH_FLAG;
                        end
                    end
                    PH_LEN: begin
                        hdr_move = 1'b1;
                        n_exp    = {r_fmt[3:0] & hfd_pkg::LEN_HI_MASK[3:0], i_data_byte};
                        n_wp     = WP_W'(hfd_pkg::HDR_N);
                        n_phase  = PH_BODY;
                    end
                    PH_BODY: begin
                        wr_en = 1'b1;
                        n_wp  = wp_inc;
                        if (wp_inc_cw == end_pos) begin
                            if (i_data_byte == hfd_pkg::FLAG_BYTE) begin
                                n_ready = 1'b1;
                                n_kind  = hfd_pkg::KIND_COMPLETE;
                                n_len   = wp_inc_cw[hfd_pkg::LEN_W-1:0];
                                n_wp    = '0;
                            end
                            n_phase = PH_FLAG;
                        end
                    end
                    default: begin
                        n_phase = PH_FLAG;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAG;
            r_wp        <= '0;
            r_exp       <= '0;
            r_kind      <= hfd_pkg::KIND_TRASH;
            r_len       <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_wp    <= n_wp;
                r_exp   <= n_exp;
                r_kind  <= n_kind;
                r_len   <= n_len;
                r_ready <= n_ready;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // header bytes and read result path
    always_ff @(posedge i_clk) begin
        if (push && r_phase == PH_FMT) begin
            r_fmt <= i_data_byte;
        end
        if (hdr_move) begin
            r_hdr[0] <= hfd_pkg::FLAG_BYTE;
            r_hdr[1] <= r_fmt;
            r_hdr[2] <= i_data_byte;
        end else if (wr_hdr) begin
            r_hdr[r_wp[1:0]] <= i_data_byte;
        end
        if (accept) begin
            r_rd_sel_mem <= rd_mem_en;
            if (rd && idx_in_hdr) begin
                r_rd_byte <= r_hdr[i_read_index[1:0]];
            end else begin
                r_rd_byte <= '0;
            end
        end
    end

    // frame buffer memory
    always_ff @(posedge i_clk) begin
        if (wr_mem) begin
            mem[r_wp[AW-1:0]] <= i_data_byte;
        end
        if (rd_mem_en) begin
            r_mem_q <= mem[idx_cw[AW-1:0]];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ready  = r_ready;
    assign o_frame_kind   = r_kind;
    assign o_frame_length = r_len;
    assign o_read_data    = r_rd_sel_mem ? r_mem_q : r_rd_byte;

endmodule

// File: design/hdlc_frame_deframer_core_checker.sv
// hdlc_frame_deframer_core_checker: port-level assertions for the deframer
// bound to hdlc_frame_deframer_core, depends on hfd_pkg
module hdlc_frame_deframer_core_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         o_frame_ready,
    input  logic                         o_frame_kind,
    input  logic [hfd_pkg::LEN_W-1:0]    o_frame_length,
    input  logic [hfd_pkg::DATA_W-1:0]   o_read_data
);

    logic                       r_last_kind;
    logic [hfd_pkg::LEN_W-1:0]  r_last_len;

    // last reported frame as seen on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_kind <= hfd_pkg::KIND_TRASH;
            r_last_len  <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_last_kind <= o_frame_kind;
            r_last_len  <= o_frame_length;
        end
    end

    a_read_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_data != '0) |-> !o_frame_ready)
        else $error("read transaction flagged a frame");

    a_report_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_ready) |->
            (o_frame_kind == r_last_kind && o_frame_length == r_last_len))
        else $error("frame report changed without a frame");

    a_result_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result without an accepted transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_frame_ready) && $stable(o_frame_kind)
             && $stable(o_frame_length) && $stable(o_read_data)))
        else $error("stalled result changed");

endmodule

bind hdlc_frame_deframer_core hdlc_frame_deframer_core_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_frame_ready  (o_frame_ready),
    .o_frame_kind   (o_frame_kind),
    .o_frame_length (o_frame_length),
    .o_read_data    (o_read_data)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for hdlc_frame_deframer_core, directed table then random frames
// each transaction result is checked against the directed table or a behavioral deframer model held in this file
// depends on hfd_pkg and the design files
module tb_top;

    localparam int DATA_W  = hfd_pkg::DATA_W;
    localparam int INDEX_W = hfd_pkg::INDEX_W;
    localparam int LEN_W   = hfd_pkg::LEN_W;
    localparam int HDR_N   = hfd_pkg::HDR_N;

    localparam logic FUNC_PUSH     = hfd_pkg::FUNC_PUSH;
    localparam logic FUNC_READ     = hfd_pkg::FUNC_READ;
    localparam logic KIND_TRASH    = hfd_pkg::KIND_TRASH;
    localparam logic KIND_COMPLETE = hfd_pkg::KIND_COMPLETE;

    localparam logic [DATA_W-1:0] FLAG_BYTE   = hfd_pkg::FLAG_BYTE;
    localparam logic [DATA_W-1:0] FMT_MASK    = hfd_pkg::FMT_MASK;
    localparam logic [DATA_W-1:0] FMT_TYPE    = hfd_pkg::FMT_TYPE;
    localparam logic [DATA_W-1:0] LEN_HI_MASK = hfd_pkg::LEN_HI_MASK;

    localparam int BUF_N       = hfd_pkg::BUF_SIZE_DEF;
    localparam int N_RANDOM    = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int IDLE_PCT    = 11;
    localparam int HOLD_CYCLES = 64;
    localparam int N_ROWS      = 26;

    typedef enum logic [1:0] {PH_HUNT, PH_FORMAT, PH_LENGTH, PH_BODY} t_phase;

    typedef struct packed {
        logic              ready;
        logic              kind;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] rdata;
    } t_frame_res;

    typedef struct packed {
        logic               func;
        logic [DATA_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               fixed;
        t_frame_res         want;
    } t_dir_row;

    localparam t_frame_res NO_RES = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_func = FUNC_PUSH;
    logic [DATA_W-1:0]  i_data_byte = '0;
    logic [INDEX_W-1:0] i_read_index = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_frame_ready;
    logic               o_frame_kind;
    logic [LEN_W-1:0]   o_frame_length;
    logic [DATA_W-1:0]  o_read_data;

    // deframer model state
    logic [DATA_W-1:0] shadow_buf [BUF_N];
    int                wr_pos = 0;
    t_phase            parse_st = PH_HUNT;
    int                frame_len_exp = 0;
    logic              last_kind = KIND_TRASH;
    logic [LEN_W-1:0]  last_len = '0;
    int                filled_n = 0;

    t_frame_res        pending_q [$];
    t_frame_res        head_res;
    t_dir_row          dir_rows [N_ROWS];
    int                n_err = 0;
    int                n_sent = 0;
    int                cycle_n = 0;
    bit                calm = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;

    hdlc_frame_deframer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_ready  (o_frame_ready),
        .o_frame_kind   (o_frame_kind),
        .o_frame_length (o_frame_length),
        .o_read_data    (o_read_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void store_byte(input logic [DATA_W-1:0] b);
        if (wr_pos < BUF_N) begin
            shadow_buf[wr_pos] = b;
            if (wr_pos >= filled_n) filled_n = wr_pos + 1;
        end
        wr_pos++;
    endfunction

    function automatic logic note_frame(input logic kind, input int len);
        last_kind = kind;
        last_len = len[LEN_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_frame_res deframe_step(input logic func,
                                                input logic [DATA_W-1:0] b,
                                                input logic [INDEX_W-1:0] idx);
        t_frame_res r;
        logic [DATA_W-1:0] prev;
        r = '0;
        if (func == FUNC_READ) begin
            r.rdata = shadow_buf[idx];
        end else if (wr_pos >= BUF_N) begin
            wr_pos = 0;
            parse_st = PH_HUNT;
            frame_len_exp = 0;
            r.ready = note_frame(KIND_TRASH, BUF_N);
        end else begin
            case (parse_st)
                PH_HUNT: begin
                    store_byte(b);
                    if (b == FLAG_BYTE) parse_st = PH_FORMAT;
                end
                PH_FORMAT: begin
                    store_byte(b);
                    if ((b & FMT_MASK) == FMT_TYPE) begin
                        parse_st = PH_LENGTH;
                        if (wr_pos > 2) r.ready = note_frame(KIND_TRASH, wr_pos - 2);
                    end else if (b == FLAG_BYTE) begin
                        r.ready = note_frame(KIND_TRASH, wr_pos - 1);
                    end else begin
                        parse_st = PH_HUNT;
                    end
                end
                PH_LENGTH: begin
                    // header moves to the buffer start
                    prev = shadow_buf[wr_pos - 1];
                    shadow_buf[0] = FLAG_BYTE;
                    shadow_buf[1] = prev;
                    shadow_buf[2] = b;
                    frame_len_exp = int'({prev & LEN_HI_MASK, b});
                    wr_pos = HDR_N;
                    parse_st = PH_BODY;
                    if (filled_n < HDR_N) filled_n = HDR_N;
                end
                default: begin
                    store_byte(b);
                    if (wr_pos == frame_len_exp + 2) begin
                        if (b == FLAG_BYTE) begin
                            r.ready = note_frame(KIND_COMPLETE, wr_pos);
                            wr_pos = 0;
                        end
                        parse_st = PH_HUNT;
                    end
                end
            endcase
        end
        r.kind = last_kind;
        r.length = last_len;
        return r;
    endfunction

    // neither a flag nor a format byte
    function automatic logic [DATA_W-1:0] stray_byte();
        logic [DATA_W-1:0] b;
        b = DATA_W'($urandom_range(0, 255));
        if (b == FLAG_BYTE || (b & FMT_MASK) == FMT_TYPE) b = b ^ 8'h10;
        return b;
    endfunction

    task automatic send_item(input logic func, input logic [DATA_W-1:0] b,
                             input logic [INDEX_W-1:0] idx, input logic fixed,
                             input t_frame_res want);
        t_frame_res pred;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_data_byte  <= b;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        pred = deframe_step(func, b, idx);
        pending_q.push_back(fixed ? want : pred);
        n_sent++;
    endtask

    task automatic read_any();
        if (filled_n > 0)
            send_item(FUNC_READ, DATA_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, filled_n - 1)), 1'b0, NO_RES);
    endtask

    task automatic push_rx_byte(input logic [DATA_W-1:0] b);
        if ($urandom_range(0, 9) == 0) read_any();
        send_item(FUNC_PUSH, b, INDEX_W'($urandom_range(0, 511)), 1'b0, NO_RES);
    endtask

    task automatic send_frame(input bit broken);
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 510)
                                           : $urandom_range(2, 24);
        repeat ($urandom_range(0, 2)) push_rx_byte(stray_byte());
        push_rx_byte(FLAG_BYTE);
        if ($urandom_range(0, 7) == 0) push_rx_byte(FLAG_BYTE);
        if (broken && $urandom_range(0, 2) == 0) begin
            push_rx_byte(stray_byte());
        end else begin
            push_rx_byte(FMT_TYPE | DATA_W'(len >> 8));
            push_rx_byte(DATA_W'(len));
            repeat (len - 2) push_rx_byte(DATA_W'($urandom_range(0, 255)));
            push_rx_byte(broken ? stray_byte() : FLAG_BYTE);
        end
    endtask

    // runs the buffer to its end, optionally behind a header, with stray bytes that never close the frame
    task automatic fill_buffer(input bit framed);
        if (framed) begin
            push_rx_byte(FLAG_BYTE);
            push_rx_byte(FMT_TYPE | DATA_W'($urandom_range(0, 15)));
            push_rx_byte(DATA_W'($urandom_range(0, 1)));
        end
        while (wr_pos < BUF_N) push_rx_byte(stray_byte());
        push_rx_byte(DATA_W'($urandom_range(0, 255)));
    endtask

    function automatic void check_field(input string what, input logic [LEN_W-1:0] want,
                                        input logic [LEN_W-1:0] got);
        if (got !== want) begin
            n_err++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
        end
    endfunction

    // output receiver with random stalls and one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                n_err++;
                $display("%0t ns: result transaction with none pending", $time);
            end else begin
                head_res = pending_q.pop_front();
                check_field("frame_ready", LEN_W'(head_res.ready), LEN_W'(o_frame_ready));
                check_field("frame_kind", LEN_W'(head_res.kind), LEN_W'(o_frame_kind));
                check_field("frame_length", head_res.length, o_frame_length);
                check_field("read_data", LEN_W'(head_res.rdata), LEN_W'(o_read_data));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("%0t ns: timeout", $time);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int pick;
        int wait_n;
        dir_rows = '{
            '{FUNC_PUSH, 8'h00, 9'd0, 1'b1, '{1'b0, KIND_TRASH, 10'd0, 8'h00}},
            '{FUNC_PUSH, 8'hFF, 9'd0, 1'b1, '{1'b0, KIND_TRASH, 10'd0, 8'h00}},
            '{FUNC_READ, 8'h00, 9'd0, 1'b1, '{1'b0, KIND_TRASH, 10'd0, 8'h00}},
            '{FUNC_READ, 8'h00, 9'd1, 1'b1, '{1'b0, KIND_TRASH, 10'd0, 8'hFF}},
            '{FUNC_PUSH, 8'h7E, 9'd0, 1'b1, '{1'b0, KIND_TRASH, 10'd0, 8'h00}},
            // flag instead of format
            '{FUNC_PUSH, 8'h7E, 9'd0, 1'b1, '{1'b1, KIND_TRASH, 10'd3, 8'h00}},
            '{FUNC_PUSH, 8'hA0, 9'd0, 1'b1, '{1'b1, KIND_TRASH, 10'd3, 8'h00}},
            '{FUNC_PUSH, 8'h05, 9'd0, 1'b1, '{1'b0, KIND_TRASH, 10'd3, 8'h00}},
            '{FUNC_PUSH, 8'h11, 9'd0, 1'b0, NO_RES},
            '{FUNC_PUSH, 8'h22, 9'd0, 1'b0, NO_RES},
            '{FUNC_PUSH, 8'h33, 9'd0, 1'b0, NO_RES},
            '{FUNC_PUSH, 8'h7E, 9'd0, 1'b1, '{1'b1, KIND_COMPLETE, 10'd7, 8'h00}},
            '{FUNC_READ, 8'h00, 9'd1, 1'b1, '{1'b0, KIND_COMPLETE, 10'd7, 8'hA0}},
            '{FUNC_READ, 8'h00, 9'd2, 1'b1, '{1'b0, KIND_COMPLETE, 10'd7, 8'h05}},
            // format right after a flag at buffer start
            '{FUNC_PUSH, 8'h7E, 9'd0, 1'b0, NO_RES},
            '{FUNC_PUSH, 8'hA0, 9'd0, 1'b1, '{1'b0, KIND_COMPLETE, 10'd7, 8'h00}},
            '{FUNC_PUSH, 8'h02, 9'd0, 1'b0, NO_RES},
            // wrong byte at end position
            '{FUNC_PUSH, 8'h44, 9'd0, 1'b1, '{1'b0, KIND_COMPLETE, 10'd7, 8'h00}},
            '{FUNC_PUSH, 8'h7E, 9'd0, 1'b0, NO_RES},
            // other byte instead of format
            '{FUNC_PUSH, 8'h55, 9'd0, 1'b1, '{1'b0, KIND_COMPLETE, 10'd7, 8'h00}},
            '{FUNC_PUSH, 8'h7E, 9'd0, 1'b0, NO_RES},
            '{FUNC_PUSH, 8'hA0, 9'd0, 1'b1, '{1'b1, KIND_TRASH, 10'd6, 8'h00}},
            '{FUNC_PUSH, 8'h03, 9'd0, 1'b0, NO_RES},
            '{FUNC_PUSH, 8'h80, 9'd0, 1'b0, NO_RES},
            '{FUNC_PUSH, 8'h7E, 9'd0, 1'b1, '{1'b1, KIND_COMPLETE, 10'd5, 8'h00}},
            '{FUNC_READ, 8'h00, 9'd4, 1'b1, '{1'b0, KIND_COMPLETE, 10'd5, 8'h7E}}
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++)
            send_item(dir_rows[k].func, dir_rows[k].data, dir_rows[k].index,
                      dir_rows[k].fixed, dir_rows[k].want);

        // buffer full early so reads reach every index
        fill_buffer(1'b0);
        while (n_sent < N_ROWS + N_RANDOM) begin
            calm = (n_sent >= 700 && n_sent < 1000);
            if (!hold_done && n_sent >= 300) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(1'b0);
            else if (pick < 70)
                send_frame(1'b1);
            else if (pick < 85)
                repeat ($urandom_range(1, 8)) push_rx_byte(DATA_W'($urandom_range(0, 255)));
            else if (pick < 98)
                repeat ($urandom_range(1, 4)) read_any();
            else
                fill_buffer($urandom_range(0, 1));
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        wait_n = 0;
        while (pending_q.size() != 0 && wait_n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            n_err++;
            $display("%0t ns: %0d results never arrived", $time, pending_q.size());
        end
        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
